// ----- rtl/ompm_pkg.sv -----
// Shared types, codes and helper functions for the ordered multi-pattern prefix matcher.
package ompm_pkg;

    // Request modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_MATCH = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_NO_MATCH  = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_MATCH     = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    // ASCII letter bounds and the distance between the two cases
    localparam logic [7:0] LOWER_A  = 8'h61;
    localparam logic [7:0] LOWER_Z  = 8'h7A;
    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    // Classified request as it waits in the queue
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] pattern_index;
        logic       index_ok;
        logic [7:0] byte_value;
        logic       has_alt;
        logic [7:0] alt_byte;
        logic       first_byte;
        logic       last_byte;
    } t_cmd;

    // One registered result
    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [4:0] pattern_id;
        logic [3:0] match_length;
    } t_result;

    // Other-case letter lookup
    typedef struct packed {
        logic       has_alt;
        logic [7:0] alt_byte;
    } t_alt;

    function automatic t_alt other_case(input logic [7:0] b);
        t_alt r;
        r.has_alt  = 1'b0;
        r.alt_byte = b;
        if (b >= LOWER_A && b <= LOWER_Z) begin
            r.has_alt  = 1'b1;
            r.alt_byte = b - CASE_GAP;
        end else if (b >= UPPER_A && b <= UPPER_Z) begin
            r.has_alt  = 1'b1;
            r.alt_byte = b + CASE_GAP;
        end
        return r;
    endfunction

    // Priority encoder: index of the lowest set bit, zero when none
    function automatic logic [4:0] lowest_index(input logic [31:0] m);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/ordered_multi_pattern_prefix_matcher_top.sv -----
// Top level of the ordered multi-pattern prefix matcher: front queue, back sequencer, config.
// A subject byte's result passes the queue entry, the registered table read and the result register.
// The back end takes the next subject or pattern byte only once back in idle after its table read;
// a folded letter needs two read-modify-write passes, since the table has a single write port.
// Clear and reset (synchronous, active low) sweep the table one word a cycle, busy held high.
// case_fold resets to 0; results are a one-cycle strobe on o_valid, the receiver cannot stall.
module ordered_multi_pattern_prefix_matcher_top #(
    parameter int MAX_LEN      = 8,
    parameter int MAX_PATTERNS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_mode,
    input  logic [4:0] i_pattern_index,
    input  logic [7:0] i_byte_value,
    input  logic       i_first_byte,
    input  logic       i_last_byte,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output logic       busy,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [4:0] o_pattern_id,
    output logic [3:0] o_match_length
);

    logic              r_case_fold;
    logic              w_cmd_valid;
    ompm_pkg::t_cmd    w_cmd;
    logic              w_pop;
    logic              w_sweeping;
    ompm_pkg::t_result w_res;

    // Hold the case folding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_fold <= 1'b0;
        end else if (i_cfg_we) begin
            r_case_fold <= i_cfg_wdata;
        end
    end

    ompm_front #(
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_mode          (i_mode),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_sweeping      (w_sweeping),
        .i_pop           (w_pop),
        .o_busy          (busy),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd)
    );

    ompm_back #(
        .MAX_LEN      (MAX_LEN),
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_case_fold (r_case_fold),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_sweeping  (w_sweeping),
        .o_result    (w_res)
    );

    assign o_valid        = w_res.valid;
    assign o_status       = w_res.status;
    assign o_pattern_id   = w_res.pattern_id;
    assign o_match_length = w_res.match_length;

`ifndef SYNTH
    // No result leaves while the table is being swept
    a_quiet_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweeping |-> !o_valid)
        else $error("result strobe during table sweep");

    // Only a match carries a length
    a_len_only_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ompm_pkg::ST_MATCH) |-> (o_match_length == 4'd0))
        else $error("nonzero length on a non-match result");

    // No-match and too-short results carry pattern id zero
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ompm_pkg::ST_NO_MATCH ||
                     o_status == ompm_pkg::ST_TOO_SHORT)) |-> (o_pattern_id == 5'd0))
        else $error("pattern id set on a failed match");

    // Reset leaves the block sweeping and busy
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (w_sweeping && busy))
        else $error("no table sweep after reset");
`endif

endmodule

// ----- rtl/ompm_front.sv -----
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
module ompm_front #(
    parameter int MAX_PATTERNS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_mode,
    input  logic [4:0]     i_pattern_index,
    input  logic [7:0]     i_byte_value,
    input  logic           i_first_byte,
    input  logic           i_last_byte,
    input  logic           i_sweeping,
    input  logic           i_pop,
    output logic           o_busy,
    output logic           o_cmd_valid,
    output ompm_pkg::t_cmd o_cmd
);

    localparam logic [1:0] Q_DEPTH = 2'd2;

    ompm_pkg::t_cmd r_q [0:1];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;

    ompm_pkg::t_cmd w_cmd;
    ompm_pkg::t_alt w_alt;
    logic           w_push;

    // Classify the incoming request
    always_comb begin
        w_alt               = ompm_pkg::other_case(i_byte_value);
        w_cmd.kind          = i_mode;
        w_cmd.pattern_index = i_pattern_index;
        w_cmd.index_ok      = ({1'b0, i_pattern_index} < 6'(MAX_PATTERNS));
        w_cmd.byte_value    = i_byte_value;
        w_cmd.has_alt       = w_alt.has_alt;
        w_cmd.alt_byte      = w_alt.alt_byte;
        w_cmd.first_byte    = i_first_byte;
        w_cmd.last_byte     = i_last_byte;
    end

    assign o_busy = (r_cnt == Q_DEPTH) || i_sweeping;
    // Drop the unused mode here: it has no effect downstream
    assign w_push = i_start && !o_busy && (i_mode != ompm_pkg::MODE_NONE);

    // Advance queue pointers
    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

// ----- rtl/ompm_back.sv -----
// Back end: mask table memory, table clear, pattern load and subject match sequencer.
module ompm_back #(
    parameter int MAX_LEN      = 8,
    parameter int MAX_PATTERNS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_case_fold,
    input  logic              i_cmd_valid,
    input  ompm_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_sweeping,
    output ompm_pkg::t_result o_result
);

    localparam int MP        = MAX_PATTERNS;
    localparam int WW        = 2 * MP;
    localparam int PW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PSW       = $clog2(MAX_LEN + 1);
    localparam int AW        = PW + 8;
    localparam int TBL_DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CLEAR   = 3'd1;
    localparam logic [2:0] S_EVAL    = 3'd2;
    localparam logic [2:0] S_WR_MAIN = 3'd3;
    localparam logic [2:0] S_WR_ALT  = 3'd4;

    // Table: end mask in the upper half, match mask in the lower half
    logic [WW-1:0] r_mem [0:TBL_DEPTH-1];
    logic [WW-1:0] r_rd_data;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [MP-1:0] r_alive, n_alive;
    logic [MP-1:0] r_ended, n_ended;
    logic [PSW-1:0] r_best, n_best;
    logic [PSW-1:0] r_spos, n_spos;
    logic          r_decided, n_decided;
    logic [PSW-1:0] r_ppos, n_ppos;
    logic [7:0]    r_prev, n_prev;
    logic [AW-1:0] r_addr_main, n_addr_main;
    logic [AW-1:0] r_addr_alt, n_addr_alt;
    logic          r_need_alt, n_need_alt;
    logic [WW-1:0] r_or_word, n_or_word;
    logic          r_last, n_last;
    ompm_pkg::t_result r_res, n_res;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [WW-1:0] w_wd;

    logic [MP-1:0] w_bit;
    logic [PSW-1:0] w_ppos_eff;
    logic [PSW-1:0] w_spos_eff;
    logic          w_dec_eff;
    ompm_pkg::t_alt w_alt_prev;
    logic [MP-1:0] w_cur;
    logic [MP-1:0] w_ends;
    logic [MP-1:0] w_head;
    logic          w_head_end;
    logic [MP-1:0] w_ended_sel;
    logic [4:0]    w_head_idx;
    logic [4:0]    w_ended_idx;
    logic [4:0]    w_stored_idx;
    logic [PSW-1:0] w_pos_next;
    logic [PSW-1:0] w_best_sel;

    // Request decode terms
    assign w_bit      = MP'(1) << i_cmd.pattern_index;
    assign w_ppos_eff = i_cmd.first_byte ? '0 : r_ppos;
    assign w_spos_eff = i_cmd.first_byte ? '0 : r_spos;
    assign w_dec_eff  = i_cmd.first_byte ? 1'b0 : r_decided;
    assign w_alt_prev = ompm_pkg::other_case(r_prev);

    // Subject byte evaluation terms from the registered table word
    assign w_cur        = r_alive & r_rd_data[MP-1:0];
    assign w_ends       = r_rd_data[WW-1:MP] & w_cur;
    assign w_head       = w_cur & (~w_cur + MP'(1));
    assign w_head_end   = |(w_ends & w_head);
    assign w_ended_sel  = (w_ends != '0) ? w_ends : r_ended;
    assign w_head_idx   = ompm_pkg::lowest_index(32'(w_cur));
    assign w_ended_idx  = ompm_pkg::lowest_index(32'(w_ended_sel));
    assign w_stored_idx = ompm_pkg::lowest_index(32'(r_ended));
    assign w_pos_next   = r_spos + PSW'(1);
    assign w_best_sel   = (w_ends != '0) ? w_pos_next : r_best;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_alive     = r_alive;
        n_ended     = r_ended;
        n_best      = r_best;
        n_spos      = r_spos;
        n_decided   = r_decided;
        n_ppos      = r_ppos;
        n_prev      = r_prev;
        n_addr_main = r_addr_main;
        n_addr_alt  = r_addr_alt;
        n_need_alt  = r_need_alt;
        n_or_word   = r_or_word;
        n_last      = r_last;
        n_res       = '0;
        o_pop       = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr_main;
        w_we        = 1'b0;
        w_wa        = r_clr_addr;
        w_wd        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        ompm_pkg::MODE_CLEAR: begin
                            // Reset all matching state, then sweep the table
                            n_alive    = '1;
                            n_ended    = '0;
                            n_best     = '0;
                            n_spos     = '0;
                            n_decided  = 1'b0;
                            n_ppos     = '0;
                            n_prev     = '0;
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        ompm_pkg::MODE_LOAD: begin
                            if (i_cmd.first_byte) begin
                                n_ppos = '0;
                            end
                            if (!i_cmd.index_ok) begin
                                n_res.valid      = 1'b1;
                                n_res.status     = ompm_pkg::ST_DROPPED;
                                n_res.pattern_id = i_cmd.pattern_index;
                            end else if (w_ppos_eff < PSW'(MAX_LEN)) begin
                                // Set match bit, and end bit on the last byte
                                n_addr_main = {w_ppos_eff[PW-1:0], i_cmd.byte_value};
                                n_addr_alt  = {w_ppos_eff[PW-1:0], i_cmd.alt_byte};
                                n_need_alt  = i_case_fold && i_cmd.has_alt;
                                n_or_word   = {(i_cmd.last_byte ? w_bit : {MP{1'b0}}), w_bit};
                                n_prev      = i_cmd.byte_value;
                                n_ppos      = w_ppos_eff + PSW'(1);
                                w_rd_en     = 1'b1;
                                w_rd_addr   = n_addr_main;
                                n_state     = S_WR_MAIN;
                            end else begin
                                // Byte past depth: drop it; on the last byte, repair the end mark
                                n_res.valid      = 1'b1;
                                n_res.status     = ompm_pkg::ST_DROPPED;
                                n_res.pattern_id = i_cmd.pattern_index;
                                if (i_cmd.last_byte) begin
                                    n_addr_main = {PW'(MAX_LEN - 1), r_prev};
                                    n_addr_alt  = {PW'(MAX_LEN - 1), w_alt_prev.alt_byte};
                                    n_need_alt  = i_case_fold && w_alt_prev.has_alt;
                                    n_or_word   = {w_bit, {MP{1'b0}}};
                                    w_rd_en     = 1'b1;
                                    w_rd_addr   = n_addr_main;
                                    n_state     = S_WR_MAIN;
                                end
                            end
                        end
                        ompm_pkg::MODE_MATCH: begin
                            if (i_cmd.first_byte) begin
                                n_alive   = '1;
                                n_ended   = '0;
                                n_best    = '0;
                                n_spos    = '0;
                                n_decided = 1'b0;
                            end
                            if (!w_dec_eff) begin
                                if (w_spos_eff < PSW'(MAX_LEN)) begin
                                    n_addr_main = {w_spos_eff[PW-1:0], i_cmd.byte_value};
                                    n_last      = i_cmd.last_byte;
                                    w_rd_en     = 1'b1;
                                    w_rd_addr   = n_addr_main;
                                    n_state     = S_EVAL;
                                end else if (i_cmd.last_byte) begin
                                    // Past depth: the subject end still decides
                                    n_decided   = 1'b1;
                                    n_res.valid = 1'b1;
                                    if (!i_cmd.first_byte && r_ended != '0) begin
                                        n_res.status       = ompm_pkg::ST_MATCH;
                                        n_res.pattern_id   = w_stored_idx;
                                        n_res.match_length = 4'(r_best);
                                    end else begin
                                        n_res.status = ompm_pkg::ST_TOO_SHORT;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                // Zero one table word per cycle
                w_we       = 1'b1;
                w_wa       = r_clr_addr;
                w_wd       = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (w_cur == '0) begin
                    // Mismatch: report the latest completed pattern, if any
                    n_decided   = 1'b1;
                    n_res.valid = 1'b1;
                    if (r_ended != '0) begin
                        n_res.status       = ompm_pkg::ST_MATCH;
                        n_res.pattern_id   = w_ended_idx;
                        n_res.match_length = 4'(r_best);
                    end else begin
                        n_res.status = ompm_pkg::ST_NO_MATCH;
                    end
                end else begin
                    if (w_ends != '0) begin
                        n_ended = w_ends;
                        n_best  = w_pos_next;
                    end
                    if (w_head_end) begin
                        // Highest-priority live pattern ends here: it wins
                        n_decided          = 1'b1;
                        n_res.valid        = 1'b1;
                        n_res.status       = ompm_pkg::ST_MATCH;
                        n_res.pattern_id   = w_head_idx;
                        n_res.match_length = 4'(w_pos_next);
                    end else begin
                        n_alive = w_cur;
                        n_spos  = w_pos_next;
                        if (r_last) begin
                            n_decided   = 1'b1;
                            n_res.valid = 1'b1;
                            if (w_ended_sel != '0) begin
                                n_res.status       = ompm_pkg::ST_MATCH;
                                n_res.pattern_id   = w_ended_idx;
                                n_res.match_length = 4'(w_best_sel);
                            end else begin
                                n_res.status = ompm_pkg::ST_TOO_SHORT;
                            end
                        end
                    end
                end
            end
            S_WR_MAIN: begin
                // Write back the primary entry, fetch the other-case entry if needed
                w_we = 1'b1;
                w_wa = r_addr_main;
                w_wd = r_rd_data | r_or_word;
                if (r_need_alt) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr_alt;
                    n_state   = S_WR_ALT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WR_ALT: begin
                w_we    = 1'b1;
                w_wa    = r_addr_alt;
                w_wd    = r_rd_data | r_or_word;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_alive    <= '1;
            r_ended    <= '0;
            r_best     <= '0;
            r_spos     <= '0;
            r_decided  <= 1'b0;
            r_ppos     <= '0;
            r_prev     <= '0;
            r_res      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_alive    <= n_alive;
            r_ended    <= n_ended;
            r_best     <= n_best;
            r_spos     <= n_spos;
            r_decided  <= n_decided;
            r_ppos     <= n_ppos;
            r_prev     <= n_prev;
            r_res      <= n_res;
        end
    end

    // Operation payload
    always_ff @(posedge i_clk) begin
        r_addr_main <= n_addr_main;
        r_addr_alt  <= n_addr_alt;
        r_need_alt  <= n_need_alt;
        r_or_word   <= n_or_word;
        r_last      <= n_last;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_sweeping = (r_state == S_CLEAR);
    assign o_result   = r_res;

endmodule

// ----- tb/sv/ordered_multi_pattern_prefix_matcher_top_tb.sv -----
// Self-checking testbench for the ordered multi-pattern prefix matcher top level.
`timescale 1ns / 1ps

module ordered_multi_pattern_prefix_matcher_top_tb;

    localparam int MAX_LEN       = 8;
    localparam int MAX_PATTERNS  = 32;
    localparam int MAX_PAT_BYTES = 10;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic [1:0] i_mode;
    logic [4:0] i_pattern_index;
    logic [7:0] i_byte_value;
    logic       i_first_byte;
    logic       i_last_byte;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       busy;
    logic       o_valid;
    logic [1:0] o_status;
    logic [4:0] o_pattern_id;
    logic [3:0] o_match_length;

    ordered_multi_pattern_prefix_matcher_top #(
        .MAX_LEN      (MAX_LEN),
        .MAX_PATTERNS (MAX_PATTERNS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_mode          (i_mode),
        .i_pattern_index (i_pattern_index),
        .i_byte_value    (i_byte_value),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_pattern_id    (o_pattern_id),
        .o_match_length  (o_match_length)
    );

    // Predicted matcher state
    logic [31:0] hit_mask  [MAX_LEN][256];
    logic [31:0] stop_mask [MAX_LEN][256];
    logic        fold_on;
    logic [31:0] live_set;
    logic [31:0] done_set;
    logic [3:0]  done_len;
    int          subj_pos;
    int          pat_pos;
    logic [7:0]  last_pat_byte;
    logic        settled;

    ompm_pkg::t_result pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      gaps_on;

    // Patterns currently in the table, used to build matching subjects
    logic [7:0] pat_text [MAX_PATTERNS][MAX_PAT_BYTES];
    int         pat_len  [MAX_PATTERNS];
    int         loaded_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run with a failure past the cycle limit, as when the block stops making progress
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic is_letter(logic [7:0] b);
        return (b >= ompm_pkg::UPPER_A && b <= ompm_pkg::UPPER_Z) ||
               (b >= ompm_pkg::LOWER_A && b <= ompm_pkg::LOWER_Z);
    endfunction

    function automatic logic [4:0] first_set(logic [31:0] m);
        for (int i = 0; i < 32; i++) begin
            if (m[i]) return 5'(i);
        end
        return 5'd0;
    endfunction

    function automatic ompm_pkg::t_result make_result(logic [1:0] st, logic [4:0] id,
                                                      logic [3:0] len);
        ompm_pkg::t_result r;
        r.valid        = 1'b1;
        r.status       = st;
        r.pattern_id   = id;
        r.match_length = len;
        return r;
    endfunction

    // Set a pattern bit in one table, adding the other-case letter when folding
    function automatic void mark_table(bit to_stop, int pos, logic [7:0] b, logic [31:0] bits);
        logic       has_alt;
        logic [7:0] alt;
        has_alt = fold_on && is_letter(b);
        alt     = b ^ ompm_pkg::CASE_GAP;
        if (to_stop) begin
            stop_mask[pos][b] |= bits;
            if (has_alt) stop_mask[pos][alt] |= bits;
        end else begin
            hit_mask[pos][b] |= bits;
            if (has_alt) hit_mask[pos][alt] |= bits;
        end
    endfunction

    function automatic void restart_subject();
        live_set = '1;
        done_set = '0;
        done_len = 4'd0;
        subj_pos = 0;
        settled  = 1'b0;
    endfunction

    function automatic void clear_all();
        foreach (hit_mask[p, v]) begin
            hit_mask[p][v]  = '0;
            stop_mask[p][v] = '0;
        end
        restart_subject();
        pat_pos       = 0;
        last_pat_byte = 8'd0;
    endfunction

    // Advance the predicted state by one request and return its result, if any
    function automatic ompm_pkg::t_result predict_request(logic [1:0] mode, logic [4:0] idx,
                                                          logic [7:0] b, logic is_first,
                                                          logic is_last);
        logic [31:0]       bits;
        logic [31:0]       cur;
        logic [31:0]       ends;
        logic [31:0]       head;
        ompm_pkg::t_result none;
        none = '0;
        case (mode)
            ompm_pkg::MODE_CLEAR: begin
                clear_all();
                return none;
            end
            ompm_pkg::MODE_LOAD: begin
                if (is_first) pat_pos = 0;
                if (idx >= MAX_PATTERNS) return make_result(ompm_pkg::ST_DROPPED, idx, 4'd0);
                bits = 32'd1 << idx;
                if (pat_pos < MAX_LEN) begin
                    mark_table(1'b0, pat_pos, b, bits);
                    if (is_last) mark_table(1'b1, pat_pos, b, bits);
                    last_pat_byte = b;
                    pat_pos++;
                    return none;
                end
                // Byte past depth: drop it but keep the end mark in range
                if (is_last) mark_table(1'b1, MAX_LEN - 1, last_pat_byte, bits);
                return make_result(ompm_pkg::ST_DROPPED, idx, 4'd0);
            end
            ompm_pkg::MODE_MATCH: begin
                if (is_first) restart_subject();
                if (settled) return none;
                if (subj_pos < MAX_LEN) begin
                    cur = live_set & hit_mask[subj_pos][b];
                    if (cur == '0) begin
                        settled = 1'b1;
                        if (done_set != '0) begin
                            return make_result(ompm_pkg::ST_MATCH, first_set(done_set),
                                               done_len);
                        end
                        return make_result(ompm_pkg::ST_NO_MATCH, 5'd0, 4'd0);
                    end
                    ends = stop_mask[subj_pos][b] & cur;
                    if (ends != '0) begin
                        head     = cur & (~cur + 32'd1);
                        done_set = ends;
                        done_len = 4'(subj_pos + 1);
                        // Highest-priority live pattern ends here: decide now
                        if ((ends & head) != '0) begin
                            settled = 1'b1;
                            return make_result(ompm_pkg::ST_MATCH, first_set(head), done_len);
                        end
                    end
                    live_set = cur;
                    subj_pos++;
                end
                if (is_last) begin
                    settled = 1'b1;
                    if (done_set != '0) begin
                        return make_result(ompm_pkg::ST_MATCH, first_set(done_set), done_len);
                    end
                    return make_result(ompm_pkg::ST_TOO_SHORT, 5'd0, 4'd0);
                end
                return none;
            end
            default: return none;
        endcase
        return none;
    endfunction

    // Compare each result strobe against the oldest predicted result
    always @(posedge i_clk) begin : check_results
        ompm_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d pattern_id %0d match_length %0d",
                       o_status, o_pattern_id, o_match_length);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    error_count++;
                end
                if (o_pattern_id !== want.pattern_id) begin
                    $error("pattern_id: expected %0d actual %0d",
                           want.pattern_id, o_pattern_id);
                    error_count++;
                end
                if (o_match_length !== want.match_length) begin
                    $error("match_length: expected %0d actual %0d",
                           want.match_length, o_match_length);
                    error_count++;
                end
            end
        end
    end

    // Send one request, idling at random first when gaps are on, and record its prediction
    task automatic issue_request(logic [1:0] mode, logic [4:0] idx, logic [7:0] b,
                                 logic is_first, logic is_last);
        ompm_pkg::t_result r;
        if (gaps_on) begin
            while ($urandom_range(99) < 22) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_pattern_index <= idx;
        i_byte_value    <= b;
        i_first_byte    <= is_first;
        i_last_byte     <= is_last;
        do @(posedge i_clk); while (busy);
        r = predict_request(mode, idx, b, is_first, is_last);
        if (r.valid) pending_results.push_back(r);
    endtask

    task automatic send_word(logic [1:0] mode, logic [4:0] id, string word);
        for (int i = 0; i < word.len(); i++) begin
            issue_request(mode, id, word[i], i == 0, i == word.len() - 1);
        end
    endtask

    // Hold off until every result is in and queued loads or sweeps are done
    task automatic settle_block();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_case_fold(logic value);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        fold_on = value;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly letters a..c in both cases, plus zero, all ones and any byte
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(255));
            default: return ($urandom_range(1) ? ompm_pkg::LOWER_A : ompm_pkg::UPPER_A) +
                            8'($urandom_range(2));
        endcase
    endfunction

    // Priority, last-completed fallback, too short, no match, dropped bytes, mode three
    task automatic test_priority_and_lengths();
        gaps_on = 1'b1;
        write_case_fold(1'b0);
        send_word(ompm_pkg::MODE_LOAD, 5'd3, "mnop");
        send_word(ompm_pkg::MODE_LOAD, 5'd4, "mn");
        issue_request(ompm_pkg::MODE_LOAD, 5'd31, 8'hFF, 1'b1, 1'b1);
        // Nine bytes: the last one is dropped and its end mark moves back in range
        for (int i = 0; i < 8; i++) begin
            issue_request(ompm_pkg::MODE_LOAD, 5'd7, 8'h00, i == 0, 1'b0);
        end
        issue_request(ompm_pkg::MODE_LOAD, 5'd7, 8'h41, 1'b0, 1'b1);
        send_word(ompm_pkg::MODE_MATCH, 5'd0, "mnx");
        send_word(ompm_pkg::MODE_MATCH, 5'd0, "m");
        issue_request(ompm_pkg::MODE_MATCH, 5'd31, 8'hFF, 1'b1, 1'b1);
        send_word(ompm_pkg::MODE_MATCH, 5'd0, "q");
        issue_request(ompm_pkg::MODE_NONE, 5'd0, 8'h00, 1'b1, 1'b1);
    endtask

    // Random patterns and subjects built from them, with some noise mixed in
    task automatic test_random_traffic(logic fold, bit gaps, int n_items);
        int         sent;
        int         id;
        int         len;
        int         pick;
        int         slen;
        logic [7:0] b;
        write_case_fold(fold);
        gaps_on = gaps;
        loaded_ids.delete();
        issue_request(ompm_pkg::MODE_CLEAR, 5'($urandom_range(31)), 8'($urandom_range(255)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        sent = 1;
        while (sent < n_items) begin
            // Add a batch of patterns at the start and now and then
            if (loaded_ids.size() == 0 || $urandom_range(19) == 0) begin
                repeat ($urandom_range(6, 3)) begin
                    id  = $urandom_range(MAX_PATTERNS - 1);
                    len = ($urandom_range(4) == 0) ? $urandom_range(MAX_PAT_BYTES, MAX_LEN + 1)
                                                   : $urandom_range(MAX_LEN, 1);
                    for (int i = 0; i < len; i++) pat_text[id][i] = pick_symbol();
                    pat_len[id] = len;
                    loaded_ids.push_back(id);
                    for (int i = 0; i < len; i++) begin
                        issue_request(ompm_pkg::MODE_LOAD, 5'(id), pat_text[id][i],
                                      (i == 0) && ($urandom_range(19) != 0), i == len - 1);
                        sent++;
                    end
                end
            end
            case ($urandom_range(19))
                0: begin
                    // Stray load, match or idle-mode request with any fields
                    issue_request(2'($urandom_range(3, 1)), 5'($urandom_range(31)),
                                  8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                    sent++;
                end
                1: begin
                    // Broken subject: random bytes, random framing
                    repeat ($urandom_range(4, 1)) begin
                        issue_request(ompm_pkg::MODE_MATCH, 5'($urandom_range(31)),
                                      8'($urandom_range(255)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)));
                        sent++;
                    end
                end
                default: begin
                    // Subject that follows a loaded pattern, with tweaks and case flips
                    pick = loaded_ids[$urandom_range(loaded_ids.size() - 1)];
                    slen = $urandom_range(pat_len[pick] + 2, 1);
                    if (slen > MAX_LEN + 3) slen = MAX_LEN + 3;
                    for (int i = 0; i < slen; i++) begin
                        b = (i < pat_len[pick] && $urandom_range(9) != 0) ? pat_text[pick][i]
                                                                          : pick_symbol();
                        if (is_letter(b) && $urandom_range(3) == 0) b = b ^ ompm_pkg::CASE_GAP;
                        issue_request(ompm_pkg::MODE_MATCH, 5'($urandom_range(31)), b,
                                      (i == 0) ? ($urandom_range(19) != 0)
                                               : ($urandom_range(49) == 0),
                                      (i == slen - 1) && ($urandom_range(19) != 0));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_mode          <= ompm_pkg::MODE_NONE;
        i_pattern_index <= 5'd0;
        i_byte_value    <= 8'd0;
        i_first_byte    <= 1'b0;
        i_last_byte     <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        clear_all();
        fold_on = 1'b0;
        gaps_on = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_priority_and_lengths();
        test_random_traffic(1'b0, 1'b1, 180);
        test_random_traffic(1'b1, 1'b1, 180);
        test_random_traffic(1'b1, 1'b0, 180);
        test_random_traffic(1'b0, 1'b1, 180);
        settle_block();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
